// ----- hdl/aoks_pkg.sv -----
// aoks_pkg: shared types, register indexes and aes helper functions
// for the aes ofb keystream core; no dependencies
package aoks_pkg;

    localparam int BLOCK_BYTES = 16;
    localparam int RK_ROWS     = 15;
    localparam int IDX_W       = $clog2(BLOCK_BYTES);

    // configuration register indexes
    localparam logic [2:0] REG_KEY_W0   = 3'd0;
    localparam logic [2:0] REG_KEY_W1   = 3'd1;
    localparam logic [2:0] REG_KEY_W2   = 3'd2;
    localparam logic [2:0] REG_KEY_W3   = 3'd3;
    localparam logic [2:0] REG_KEY_SIZE = 3'd4;
    localparam logic [2:0] REG_IV_HIGH  = 3'd5;
    localparam logic [2:0] REG_IV_LOW   = 3'd6;

    // key size codes; the spare code behaves as 256 bit
    localparam logic [1:0] KSZ_128     = 2'd0;
    localparam logic [1:0] KSZ_192     = 2'd1;
    localparam logic [1:0] KSZ_256     = 2'd2;
    localparam logic [1:0] KSZ_256_ALT = 2'd3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_in;
    } aoks_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_out;
    } aoks_out_t;

    // round key row write from key schedule to cipher
    typedef struct packed {
        logic         en;
        logic [3:0]   row;
        logic [127:0] data;
    } aoks_rk_wr_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    // multiply by x in gf(2^8)
    function automatic logic [7:0] xt(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    // words of key in use; code three behaves as 256 bit
    function automatic logic [3:0] key_words_in_use(input logic [1:0] code);
        logic [3:0] nk;
        case (code)
            KSZ_128: nk = 4'd4;
            KSZ_192: nk = 4'd6;
            default: nk = 4'd8;
        endcase
        return nk;
    endfunction

    function automatic logic [3:0] num_rounds(input logic [1:0] code);
        return key_words_in_use(code) + 4'd6;
    endfunction

endpackage

// ----- hdl/aoks_key_sched.sv -----
// aoks_key_sched: iterative aes key expansion, one 32-bit word per cycle,
// emits a round key row every fourth word; depends on aoks_pkg
module aoks_key_sched import aoks_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [1:0]   key_size,
    input  logic [255:0] key_bits,
    output aoks_rk_wr_t  rk_wr,
    output logic         done
);

    logic        busy_reg;
    logic        done_reg;
    logic [5:0]  idx_reg;
    logic [2:0]  mod_reg;
    logic [7:0]  rc_reg;
    logic [31:0] win_reg [8];
    logic [31:0] row_reg [3];

    logic [3:0]  nk;
    logic [5:0]  last_idx;
    logic [31:0] prev_w;
    logic [31:0] far_w;
    logic [31:0] tmp_w;
    logic [31:0] key_w;
    logic [31:0] new_w;
    logic        from_key;
    logic [2:0]  mod_next;

    always_comb begin
        nk       = key_words_in_use(key_size);
        last_idx = {nk, 2'b00} + 6'd27;
        prev_w   = win_reg[0];
        case (key_size)
            KSZ_128: far_w = win_reg[3];
            KSZ_192: far_w = win_reg[5];
            default: far_w = win_reg[7];
        endcase
        if (mod_reg == 3'd0) begin
            tmp_w = sub_word({prev_w[23:0], prev_w[31:24]}) ^ {rc_reg, 24'h000000};
        end else if (nk == 4'd8 && mod_reg == 3'd4) begin
            tmp_w = sub_word(prev_w);
        end else begin
            tmp_w = prev_w;
        end
        key_w    = key_bits[{~idx_reg[2:0], 5'b00000} +: 32];
        from_key = ({2'b00, nk} > idx_reg);
        new_w    = from_key ? key_w : (far_w ^ tmp_w);
        mod_next = (mod_reg == 3'(nk - 4'd1)) ? 3'd0 : mod_reg + 3'd1;
    end

    assign rk_wr.en   = busy_reg && (idx_reg[1:0] == 2'd3);
    assign rk_wr.row  = idx_reg[5:2];
    assign rk_wr.data = {row_reg[0], row_reg[1], row_reg[2], new_w};
    assign done       = done_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            idx_reg  <= '0;
            mod_reg  <= '0;
            rc_reg   <= 8'h01;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                idx_reg  <= '0;
                mod_reg  <= '0;
                rc_reg   <= 8'h01;
            end else if (busy_reg) begin
                idx_reg <= idx_reg + 6'd1;
                mod_reg <= mod_next;
                if (!from_key && mod_reg == 3'd0) begin
                    rc_reg <= xt(rc_reg);
                end
                if (idx_reg == last_idx) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // word window and partial row
    always_ff @(posedge aclk) begin
        if (busy_reg && !start) begin
            win_reg[0] <= new_w;
            for (int k = 1; k < 8; k++) begin
                win_reg[k] <= win_reg[k-1];
            end
            if (idx_reg[1:0] != 2'd3) begin
                row_reg[idx_reg[1:0]] <= new_w;
            end
        end
    end

endmodule

// ----- hdl/aoks_cipher.sv -----
// aoks_cipher: round-iterative aes encryption, one round per cycle,
// holds the round key memory and the feedback block; depends on aoks_pkg
module aoks_cipher import aoks_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  aoks_rk_wr_t  rk_wr,
    input  logic         start,
    input  logic [3:0]   num_rnd,
    input  logic [127:0] init_block,
    output logic [127:0] block,
    output logic         done
);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_LOAD = 2'd1;
    localparam logic [1:0] PH_RUN  = 2'd2;

    logic [127:0] rk_mem [RK_ROWS];
    logic [127:0] rk_q;
    logic [3:0]   rk_addr;
    logic [1:0]   phase_reg;
    logic [3:0]   rnd_reg;
    logic [127:0] blk_reg;
    logic         done_reg;
    logic [127:0] round_out;

    function automatic logic [127:0] aes_round(input logic [127:0] s, input logic last);
        logic [7:0]   b [16];
        logic [7:0]   a0, a1, a2, a3, al;
        logic [127:0] r;
        for (int c = 0; c < 4; c++) begin
            for (int i = 0; i < 4; i++) begin
                b[4*c+i] = SBOX[s[127-8*(4*((c+i)%4)+i) -: 8]];
            end
        end
        if (!last) begin
            for (int c = 0; c < 4; c++) begin
                a0 = b[4*c];
                a1 = b[4*c+1];
                a2 = b[4*c+2];
                a3 = b[4*c+3];
                al = a0 ^ a1 ^ a2 ^ a3;
                b[4*c]   = a0 ^ al ^ xt(a0 ^ a1);
                b[4*c+1] = a1 ^ al ^ xt(a1 ^ a2);
                b[4*c+2] = a2 ^ al ^ xt(a2 ^ a3);
                b[4*c+3] = a3 ^ al ^ xt(a3 ^ a0);
            end
        end
        for (int k = 0; k < 16; k++) begin
            r[127-8*k -: 8] = b[k];
        end
        return r;
    endfunction

    always_comb begin
        rk_addr   = (phase_reg == PH_RUN && rnd_reg != num_rnd) ? rnd_reg + 4'd1 : 4'd0;
        round_out = aes_round(blk_reg, rnd_reg == num_rnd);
    end

    always_ff @(posedge aclk) begin
        if (rk_wr.en) begin
            rk_mem[rk_wr.row] <= rk_wr.data;
        end
        rk_q <= rk_mem[rk_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            rnd_reg   <= '0;
            blk_reg   <= '0;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                blk_reg   <= init_block;
                phase_reg <= PH_LOAD;
            end else begin
                case (phase_reg)
                    PH_LOAD: begin
                        phase_reg <= PH_RUN;
                        rnd_reg   <= '0;
                    end
                    PH_RUN: begin
                        blk_reg <= ((rnd_reg == 4'd0) ? blk_reg : round_out) ^ rk_q;
                        if (rnd_reg == num_rnd) begin
                            phase_reg <= PH_IDLE;
                            done_reg  <= 1'b1;
                        end else begin
                            rnd_reg <= rnd_reg + 4'd1;
                        end
                    end
                    default: phase_reg <= PH_IDLE;
                endcase
            end
        end
    end

    assign block = blk_reg;
    assign done  = done_reg;

endmodule

// ----- hdl/aes_ofb_keystream_xor_core.sv -----
// aes_ofb_keystream_xor_core: aes output-feedback keystream xor, one byte per transfer
// depends on aoks_pkg, aoks_key_sched and aoks_cipher
//
//  channel  | ports                          | direction | payload
//  ---------+--------------------------------+-----------+---------------------------
//  s_       | s_valid s_ready s_data         | in        | data_byte, last_in
//  m_       | m_valid m_ready m_data         | out       | out_byte, last_out
//  cfg_     | cfg_wr_en cfg_index cfg_wdata  | in        | key words, key size, iv
//
// a byte passes straight to the output register; every sixteenth byte then holds
// s_ready low while the single round unit re-encrypts the feedback block
// a configuration write runs key expansion, one word per cycle, then encrypts
// the iv; s_ready stays low throughout
// reset is synchronous, active low; feedback block and byte index clear to zero
// the output register takes the next byte in the cycle the waiting result leaves
module aes_ofb_keystream_xor_core import aoks_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  aoks_in_t   s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output aoks_out_t  m_data,
    input  logic       cfg_wr_en,
    input  logic [2:0] cfg_index,
    input  logic [63:0] cfg_wdata
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_KEYX = 2'd1;
    localparam logic [1:0] ST_ENC  = 2'd2;

    // configuration registers
    logic [63:0] key_w0_reg, key_w1_reg, key_w2_reg, key_w3_reg;
    logic [1:0]  key_size_reg;
    logic [63:0] iv_high_reg, iv_low_reg;

    logic [1:0]       state_reg;
    logic [IDX_W-1:0] idx_reg;
    logic             m_valid_reg;
    aoks_out_t        m_data_reg;

    logic         cfg_hit;
    logic         s_xfer;
    logic         blk_end;
    logic         ks_start;
    logic         ks_done;
    logic         cph_start;
    logic         cph_done;
    logic [127:0] cph_init;
    logic [127:0] feedback;
    logic [7:0]   ks_byte;
    aoks_rk_wr_t  rk_wr;

    // any write inside the register list restarts the stream
    assign cfg_hit  = cfg_wr_en && (cfg_index <= REG_IV_LOW);
    assign s_ready  = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign s_xfer   = s_valid && s_ready;
    assign blk_end  = (idx_reg == IDX_W'(BLOCK_BYTES - 1));
    assign ks_start = cfg_hit;
    // start the iv after expansion, or re-encrypt after the sixteenth byte
    assign cph_start = !cfg_hit && ((state_reg == ST_KEYX && ks_done) || (s_xfer && blk_end));
    assign cph_init  = (state_reg == ST_KEYX) ? {iv_high_reg, iv_low_reg} : feedback;
    // byte 0 of the block sits in the top bits
    assign ks_byte   = feedback[{~idx_reg, 3'b000} +: 8];

    aoks_key_sched u_key_sched (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (ks_start),
        .key_size (key_size_reg),
        .key_bits ({key_w0_reg, key_w1_reg, key_w2_reg, key_w3_reg}),
        .rk_wr    (rk_wr),
        .done     (ks_done)
    );

    aoks_cipher u_cipher (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .rk_wr      (rk_wr),
        .start      (cph_start),
        .num_rnd    (num_rounds(key_size_reg)),
        .init_block (cph_init),
        .block      (feedback),
        .done       (cph_done)
    );

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_w0_reg   <= '0;
            key_w1_reg   <= '0;
            key_w2_reg   <= '0;
            key_w3_reg   <= '0;
            key_size_reg <= '0;
            iv_high_reg  <= '0;
            iv_low_reg   <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_KEY_W0:   key_w0_reg   <= cfg_wdata;
                REG_KEY_W1:   key_w1_reg   <= cfg_wdata;
                REG_KEY_W2:   key_w2_reg   <= cfg_wdata;
                REG_KEY_W3:   key_w3_reg   <= cfg_wdata;
                REG_KEY_SIZE: key_size_reg <= cfg_wdata[1:0];
                REG_IV_HIGH:  iv_high_reg  <= cfg_wdata;
                REG_IV_LOW:   iv_low_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // sequencer and byte index
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end else if (cfg_hit) begin
            state_reg <= ST_KEYX;
            idx_reg   <= '0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (s_xfer) begin
                        idx_reg <= idx_reg + IDX_W'(1);
                        if (blk_end) begin
                            state_reg <= ST_ENC;
                        end
                    end
                end
                ST_KEYX: begin
                    if (ks_done) begin
                        state_reg <= ST_ENC;
                    end
                end
                ST_ENC: begin
                    if (cph_done) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_xfer) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            m_data_reg.out_byte <= s_data.data_byte ^ ks_byte;
            m_data_reg.last_out <= s_data.last_in;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // bytes are only taken between keystream blocks
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> (state_reg == ST_IDLE))
        else $error("s_ready high outside idle");

    // a register write always restarts expansion
    a_cfg_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_hit |=> (state_reg == ST_KEYX) && (idx_reg == '0))
        else $error("configuration write did not restart the stream");

    // the sixteenth byte of a block starts a re-encryption
    a_block_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_xfer && blk_end && !cfg_wr_en) |=> (state_reg == ST_ENC) && (idx_reg == '0))
        else $error("block end did not start encryption");

endmodule

// ----- tb/aoks_checker.sv -----
// aoks_checker: watches the byte and configuration ports of the ofb core, predicts
// every output byte with its own aes key schedule and cipher and compares in order
// depends on aoks_pkg for the payload types, register indexes and s-box table
module aoks_checker import aoks_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  aoks_in_t    s_data,
    input  logic        m_valid,
    input  logic        m_ready,
    input  aoks_out_t   m_data,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_wdata,
    output int          fail_count,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [63:0]  key_regs [4];
    logic [1:0]   key_size;
    logic [63:0]  iv_hi, iv_lo;
    logic [127:0] feedback;
    logic [3:0]   byte_pos;
    logic [127:0] round_keys [15];
    aoks_out_t    expected_bytes [$];

    function automatic logic [7:0] gmul2(logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic int key_len_words();
        return key_size == KSZ_128 ? 4 : (key_size == KSZ_192 ? 6 : 8);
    endfunction

    function automatic void expand_round_keys();
        logic [31:0] w [60];
        logic [31:0] t;
        logic [7:0]  rc;
        int nk, total;
        nk = key_len_words();
        total = 4 * (nk + 7);
        rc = 8'h01;
        for (int i = 0; i < nk; i++)
            w[i] = (i % 2 == 0) ? key_regs[i/2][63:32] : key_regs[i/2][31:0];
        for (int i = nk; i < total; i++) begin
            t = w[i-1];
            if (i % nk == 0) begin
                t = {SBOX[t[23:16]] ^ rc, SBOX[t[15:8]], SBOX[t[7:0]], SBOX[t[31:24]]};
                rc = gmul2(rc);
            end else if (nk > 6 && i % nk == 4) begin
                t = {SBOX[t[31:24]], SBOX[t[23:16]], SBOX[t[15:8]], SBOX[t[7:0]]};
            end
            w[i] = w[i-nk] ^ t;
        end
        for (int r = 0; r < total / 4; r++)
            round_keys[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
    endfunction

    function automatic logic [127:0] aes_encrypt(logic [127:0] blk);
        logic [7:0] s [16];
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3, all;
        int nr;
        nr = key_len_words() + 6;
        for (int i = 0; i < 16; i++) s[i] = blk[127-8*i -: 8] ^ round_keys[0][127-8*i -: 8];
        for (int r = 1; r <= nr; r++) begin
            // sub bytes and shift rows together
            for (int c = 0; c < 4; c++)
                for (int i = 0; i < 4; i++)
                    t[4*c+i] = SBOX[s[4*((c+i)%4)+i]];
            if (r != nr) begin
                for (int c = 0; c < 4; c++) begin
                    a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
                    all = a0 ^ a1 ^ a2 ^ a3;
                    t[4*c]   = a0 ^ all ^ gmul2(a0 ^ a1);
                    t[4*c+1] = a1 ^ all ^ gmul2(a1 ^ a2);
                    t[4*c+2] = a2 ^ all ^ gmul2(a2 ^ a3);
                    t[4*c+3] = a3 ^ all ^ gmul2(a3 ^ a0);
                end
            end
            for (int i = 0; i < 16; i++) s[i] = t[i] ^ round_keys[r][127-8*i -: 8];
        end
        for (int i = 0; i < 16; i++) blk[127-8*i -: 8] = s[i];
        return blk;
    endfunction

    task automatic report_mismatch(string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        fail_count++;
    endtask

    initial fail_count = 0;
    initial pending = 0;

    always @(posedge aclk) begin
        aoks_out_t exp_b;
        aoks_out_t got;
        if (!aresetn) begin
            foreach (key_regs[i]) key_regs[i] = '0;
            key_size = '0;
            iv_hi    = '0;
            iv_lo    = '0;
            feedback = '0;
            byte_pos = '0;
            expected_bytes.delete();
        end else begin
            // any listed register restarts the stream; index seven is ignored
            if (cfg_wr_en && cfg_index <= REG_IV_LOW) begin
                case (cfg_index)
                    REG_KEY_W0, REG_KEY_W1, REG_KEY_W2, REG_KEY_W3:
                        key_regs[cfg_index[1:0]] = cfg_wdata;
                    REG_KEY_SIZE: key_size = cfg_wdata[1:0];
                    REG_IV_HIGH:  iv_hi = cfg_wdata;
                    default:      iv_lo = cfg_wdata;
                endcase
                expand_round_keys();
                feedback = aes_encrypt({iv_hi, iv_lo});
                byte_pos = '0;
            end
            if (s_valid && s_ready) begin
                exp_b.out_byte = s_data.data_byte ^ feedback[127-8*byte_pos -: 8];
                exp_b.last_out = s_data.last_in;
                expected_bytes.push_back(exp_b);
                if (byte_pos == 4'd15) feedback = aes_encrypt(feedback);
                byte_pos = byte_pos + 4'd1;
            end
            if (m_valid && m_ready) begin
                got = m_data;
                if (expected_bytes.size() == 0) begin
                    report_mismatch($sformatf("unexpected output byte %02h", got.out_byte));
                end else begin
                    exp_b = expected_bytes.pop_front();
                    if (got.out_byte !== exp_b.out_byte)
                        report_mismatch($sformatf("out_byte %02h, expected %02h",
                                                  got.out_byte, exp_b.out_byte));
                    if (got.last_out !== exp_b.last_out)
                        report_mismatch($sformatf("last_out %b, expected %b",
                                                  got.last_out, exp_b.last_out));
                end
            end
        end
        pending = expected_bytes.size();
    end

endmodule

// ----- tb/tb.sv -----
// tb: stimulus and verdict for aes_ofb_keystream_xor_core
// depends on aoks_pkg, the core and aoks_checker, which does all prediction
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import aoks_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    // an index past the register list
    localparam logic [2:0] REG_OUT_OF_RANGE = 3'd7;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    aoks_in_t    s_data;
    logic        m_valid;
    logic        m_ready;
    aoks_out_t   m_data;
    logic        cfg_wr_en;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_wdata;
    int          fail_count;
    int          pending;

    // idling mode: 0 none, 1 sender idles, 2 receiver stalls, 3 both
    int idle_mode;
    // long receiver hold-off, counted down by the receiver process
    int rx_hold_cycles;
    int cycle_count;

    aes_ofb_keystream_xor_core i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    aoks_checker i_checker (.*);

    always begin
        aclk = 1'b1;
        #2;
        aclk = 1'b0;
        #2;
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // receiver: random stalls per mode, plus the long hold-off when asked
    always @(negedge aclk) begin
        if (rx_hold_cycles > 0) begin
            m_ready <= 1'b0;
            rx_hold_cycles--;
        end else if (idle_mode == 2) begin
            m_ready <= ($urandom_range(99) >= 52);
        end else if (idle_mode == 3) begin
            m_ready <= ($urandom_range(99) >= 33);
        end else begin
            m_ready <= 1'b1;
        end
    end

    function automatic bit sender_idles();
        if (idle_mode == 1) return $urandom_range(99) < 52;
        if (idle_mode == 3) return $urandom_range(99) < 33;
        return 1'b0;
    endfunction

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic send_byte(logic [7:0] d, logic l);
        bit took;
        while (sender_idles()) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{data_byte: d, last_in: l};
        do begin
            @(posedge aclk);
            took = s_ready;
            @(negedge aclk);
        end while (!took);
    endtask

    task automatic send_random(int n);
        for (int i = 0; i < n; i++)
            send_byte(8'($urandom), ($urandom_range(7) == 0));
    endtask

    // wait until the core is idle: no outstanding bytes, re-encryption finished
    task automatic drain();
        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (40) @(negedge aclk);
    endtask

    // writes only happen idle; each one restarts key expansion, so let it finish
    task automatic cfg_write(logic [2:0] idx, logic [63:0] val);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        repeat (100) @(negedge aclk);
    endtask

    task automatic load_all(logic [63:0] k0, logic [63:0] k1, logic [63:0] k2,
                            logic [63:0] k3, logic [1:0] ksz,
                            logic [63:0] ivh, logic [63:0] ivl);
        cfg_write(REG_KEY_W0, k0);
        cfg_write(REG_KEY_W1, k1);
        cfg_write(REG_KEY_W2, k2);
        cfg_write(REG_KEY_W3, k3);
        cfg_write(REG_KEY_SIZE, {62'd0, ksz});
        cfg_write(REG_IV_HIGH, ivh);
        cfg_write(REG_IV_LOW, ivl);
    endtask

    function automatic logic [63:0] rand64();
        return {32'($urandom), 32'($urandom)};
    endfunction

    initial begin
        logic [63:0] all1;
        all1           = '1;
        cycle_count    = 0;
        idle_mode      = 0;
        rx_hold_cycles = 0;
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_data         = '0;
        m_ready        = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_index      = REG_KEY_W0;
        cfg_wdata      = '0;
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // all-zero 128 bit key and iv; zero input gives raw keystream
        load_all('0, '0, '0, '0, KSZ_128, '0, '0);
        for (int i = 0; i < 17; i++) send_byte(8'h00, 1'b0);
        send_byte(8'hff, 1'b1);
        send_byte(8'h55, 1'b0);
        send_byte(8'haa, 1'b1);
        send_byte(8'h01, 1'b0);
        send_byte(8'h80, 1'b1);

        // out-of-range register index: must not restart the stream
        cfg_write(REG_OUT_OF_RANGE, all1);
        send_random(20);

        // all-ones 256 bit key, long receiver hold-off so the core backs up
        load_all(all1, all1, all1, all1, KSZ_256, all1, all1);
        rx_hold_cycles = 300;
        send_random(60);
        drain();

        // random 192 bit key, sender idling
        idle_mode = 1;
        load_all(rand64(), rand64(), rand64(), rand64(), KSZ_192, rand64(), rand64());
        send_random(90);
        // sender pauses until every result is back, then carries on
        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        send_random(20);

        // key size code three acts as 256 bit; receiver stalling
        idle_mode = 2;
        load_all(rand64(), rand64(), rand64(), rand64(), KSZ_256_ALT, rand64(), rand64());
        send_random(110);

        // random 128 bit key, both sides idling; restart mid-block on iv change
        idle_mode = 3;
        load_all(rand64(), rand64(), rand64(), rand64(), KSZ_128, rand64(), rand64());
        send_random(70);
        cfg_write(REG_IV_LOW, rand64());
        send_random(60);

        idle_mode = 0;
        send_random(40);

        drain();
        repeat (50) @(negedge aclk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hdl/aoks_pkg.sv
hdl/aoks_key_sched.sv
hdl/aoks_cipher.sv
hdl/aes_ofb_keystream_xor_core.sv
tb/aoks_checker.sv
tb/tb.sv
